FILE: rtl/core/dlpo_pkg.sv
// shared widths, constants and register codes of the dust occupancy block
`default_nettype none

package dlpo_pkg;

  // transaction field widths
  localparam int unsigned PULSE_W    = 20;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WIN_W      = 20;
  localparam int unsigned CONC_W     = 32;
  localparam int unsigned SUM_W      = 40;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_MS = 1'b0,
    REG_MIN_CONC  = 1'b1
  } cfg_reg_e;

  localparam logic [WIN_W-1:0]  WINDOW_RST   = 20'd30000;
  localparam logic [CONC_W-1:0] MIN_CONC_RST = 32'd256;

  // datapath widths
  localparam int unsigned RATIO_W = 23;               // Q7.16 low ratio
  localparam int unsigned DEN_W   = 36;               // elapsed * 10
  localparam int unsigned R2_W    = 30;               // ratio squared, Q16
  localparam int unsigned R3_W    = 37;               // ratio cubed, Q16
  localparam int unsigned POS_W   = 42;               // positive curve terms
  localparam int unsigned NEG_W   = 36;               // negative curve term
  localparam int unsigned Q5_W    = 34;               // divide-by-five digit register

  // serial multiplier geometry, two multiplier bits per cycle
  localparam int unsigned MUL_AW    = 30;
  localparam int unsigned MUL_BW    = 24;
  localparam int unsigned MUL_STEPS = MUL_BW / 2;
  localparam int unsigned MUL_PW    = MUL_AW + 2 + MUL_BW;

  // floor(6.2 * 2^16), ten times the curve offset in Q16
  localparam logic [POS_W-1:0] CURVE_OFFSET = 42'd406323;

endpackage

`default_nettype wire

FILE: rtl/core/dlpo_in_if.sv
// input channel: one pulse measurement per transaction
`default_nettype none

interface dlpo_in_if;
  import dlpo_pkg::*;

  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_us;
  logic [TIME_W-1:0]  now_ms;

  modport source (output valid, output pulse_us, output now_ms, input ready);
  modport sink   (input valid, input pulse_us, input now_ms, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/dlpo_out_if.sv
// output channel: one concentration report per transaction
`default_nettype none

interface dlpo_out_if;
  import dlpo_pkg::*;

  logic              valid;
  logic              ready;
  logic [CONC_W-1:0] concentration;
  logic [SUM_W-1:0]  occupancy_total;

  modport source (output valid, output concentration, output occupancy_total, input ready);
  modport sink   (input valid, input concentration, input occupancy_total, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/dlpo_serial_mul.sv
// radix-4 shift-add multiplier, two multiplier bits per cycle
`default_nettype none

module dlpo_serial_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [dlpo_pkg::MUL_AW-1:0]   a_i,
  input  wire logic [dlpo_pkg::MUL_BW-1:0]   b_i,
  output logic      [dlpo_pkg::MUL_PW-1:0]   prod_o,
  output logic                               done_o
);
  import dlpo_pkg::*;

  localparam int unsigned CntW = $clog2(MUL_STEPS);

  logic [MUL_AW-1:0] a_q;
  logic [MUL_AW+1:0] acc_q;
  logic [MUL_BW-1:0] bsh_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [MUL_AW+2:0] pp;
  logic [MUL_AW+2:0] step_sum;
  logic              last_step;

  // partial product for the current digit and the running sum
  always_comb begin
    pp = ({3'b000, a_q} & {(MUL_AW+3){bsh_q[0]}})
       + ({2'b00, a_q, 1'b0} & {(MUL_AW+3){bsh_q[1]}});
    step_sum = {1'b0, acc_q} + pp;
  end

  assign last_step = busy_q && (cnt_q == CntW'(MUL_STEPS - 1));

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // product shifts right two bits per step, low bits leave the multiplier register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= '0;
      bsh_q <= b_i;
    end else if (busy_q) begin
      acc_q <= {1'b0, step_sum[MUL_AW+2:2]};
      bsh_q <= {step_sum[1:0], bsh_q[MUL_BW-1:2]};
    end
  end

  assign prod_o = {acc_q, bsh_q};
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/dust_low_pulse_occupancy_top.sv
// top level of the low-pulse-occupancy dust concentration block
`default_nettype none

// Each input transaction adds its pulse length to a saturating 40-bit occupancy
// sum. When the time since the window start (modulo 2^32) exceeds window_ms,
// the low ratio sum*2^16/(elapsed*10) is found one quotient bit per cycle,
// squared and cubed on a shared radix-4 serial multiplier, combined into the
// cubic curve in the POLY1 to POLY3 add states and scaled by 1/2560 with a
// divide-by-five loop of two bits per cycle. An item that closes the window
// occupies the block until it leaves FINISH; any other item returns from RANGE.
// Input ready is high only while the block is idle; a finished report sits in
// the output register while the next item is taken. The concentration and sum
// are reported, and the window restarts, only when the result reaches
// min_concentration. Configuration writes are meant for an idle block.
module dust_low_pulse_occupancy_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dlpo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dlpo_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dlpo_in_if.sink                              in_i,
  dlpo_out_if.source                           out_o
);
  import dlpo_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_RANGE  = 12'b0000_0000_0010,
    ST_LOAD   = 12'b0000_0000_0100,
    ST_DIV    = 12'b0000_0000_1000,
    ST_SQR    = 12'b0000_0001_0000,
    ST_CUBE   = 12'b0000_0010_0000,
    ST_POLY1  = 12'b0000_0100_0000,
    ST_POLY2  = 12'b0000_1000_0000,
    ST_POLY3  = 12'b0001_0000_0000,
    ST_SUB    = 12'b0010_0000_0000,
    ST_DIV5   = 12'b0100_0000_0000,
    ST_FINISH = 12'b1000_0000_0000
  } state_e;

  localparam logic [4:0] DivLast  = 5'(RATIO_W - 1);
  localparam logic [4:0] Div5Last = 5'(Q5_W / 2 - 1);

  state_e state_q, state_d;

  // control and architectural state
  logic [WIN_W-1:0]  window_q;
  logic [CONC_W-1:0] minc_q;
  logic [SUM_W-1:0]  sum_q;
  logic [TIME_W-1:0] start_q;
  logic [4:0]        cnt_q;
  logic              mul_go_q;
  logic              out_valid_q;

  // datapath registers
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  elapsed_q;
  logic [DEN_W-1:0]   den_q;
  logic [DEN_W-1:0]   rem_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [R2_W-1:0]    r2_q;
  logic [R3_W-1:0]    r3_q;
  logic [POS_W-1:0]   pos_q;
  logic [NEG_W-1:0]   neg_q;
  logic [Q5_W-1:0]    q5_q;
  logic [2:0]         rem5_q;
  logic [CONC_W-1:0]  conc_out_q;
  logic [SUM_W-1:0]   sum_out_q;

  // combinational helpers
  logic              in_fire;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic              win_closed;
  logic              ratio_sat;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_diff;
  logic              trial_ge;
  logic [4:0]        v5;
  logic [1:0]        dig5;
  logic [4:0]        sub5;
  logic [4:0]        rem5_full;
  logic [POS_W-1:0]  neg_ext;
  logic [POS_W-1:0]  t_diff;
  logic [CONC_W-1:0] conc;
  logic              emit_ok;
  logic              out_free;
  logic              emit_go;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_prod;
  logic              mul_done;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // saturating occupancy accumulation
  always_comb begin
    sum_add = {1'b0, sum_q} + (SUM_W+1)'(in_i.pulse_us);
    sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  end

  assign win_closed = elapsed_q > TIME_W'(window_q);
  // ratio overflows Q7.16 when floor(sum / 2^7) reaches the divisor
  assign ratio_sat  = (DEN_W'(sum_q[SUM_W-1:7])) >= den_q;

  // ratio division step, one quotient bit
  always_comb begin
    trial      = {rem_q, ratio_q[RATIO_W-1]};
    trial_diff = trial - {1'b0, den_q};
    trial_ge   = trial >= {1'b0, den_q};
  end

  // divide-by-five step, one base-4 digit
  always_comb begin
    v5 = {rem5_q, q5_q[Q5_W-1 -: 2]};
    if (v5 >= 5'd15) begin
      dig5 = 2'd3;
    end else if (v5 >= 5'd10) begin
      dig5 = 2'd2;
    end else if (v5 >= 5'd5) begin
      dig5 = 2'd1;
    end else begin
      dig5 = 2'd0;
    end
    sub5      = {1'b0, dig5, 2'b00} + {3'b000, dig5};
    rem5_full = v5 - sub5;
  end

  // curve difference and final saturation
  always_comb begin
    neg_ext = POS_W'(neg_q);
    t_diff  = pos_q - neg_ext;
    conc    = (|q5_q[Q5_W-1:CONC_W]) ? '1 : q5_q[CONC_W-1:0];
  end

  assign emit_ok  = conc >= minc_q;
  assign out_free = !out_valid_q || out_o.ready;
  assign emit_go  = (state_q == ST_FINISH) && emit_ok && out_free;

  // multiplier operands: ratio squared, then square times ratio
  assign mul_a = (state_q == ST_CUBE) ? r2_q : MUL_AW'(ratio_q);
  assign mul_b = MUL_BW'(ratio_q);

  dlpo_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_RANGE;
      ST_RANGE:  state_d = win_closed ? ST_LOAD : ST_IDLE;
      ST_LOAD:   state_d = ratio_sat ? ST_SQR : ST_DIV;
      ST_DIV:    if (cnt_q == DivLast) state_d = ST_SQR;
      ST_SQR:    if (mul_done) state_d = ST_CUBE;
      ST_CUBE:   if (mul_done) state_d = ST_POLY1;
      ST_POLY1:  state_d = ST_POLY2;
      ST_POLY2:  state_d = ST_POLY3;
      ST_POLY3:  state_d = ST_SUB;
      ST_SUB:    state_d = ST_DIV5;
      ST_DIV5:   if (cnt_q == Div5Last) state_d = ST_FINISH;
      ST_FINISH: if (!emit_ok || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RST;
      minc_q      <= MIN_CONC_RST;
      sum_q       <= '0;
      start_q     <= '0;
      cnt_q       <= '0;
      mul_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
      mul_go_q <= (state_d != state_q) && ((state_d == ST_SQR) || (state_d == ST_CUBE));

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WINDOW_MS: window_q <= cfg_wdata_i[WIN_W-1:0];
          REG_MIN_CONC:  minc_q   <= cfg_wdata_i[CONC_W-1:0];
          default: ;
        endcase
      end

      // occupancy sum and window bookkeeping
      if (in_fire) begin
        sum_q <= sum_sat;
      end else if (emit_go) begin
        sum_q   <= '0;
        start_q <= now_q;
      end

      // output register
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          now_q     <= in_i.now_ms;
          elapsed_q <= in_i.now_ms - start_q;
        end
      end
      ST_RANGE: begin
        den_q <= DEN_W'({elapsed_q, 3'b000}) + DEN_W'({elapsed_q, 1'b0});
      end
      ST_LOAD: begin
        if (ratio_sat) begin
          ratio_q <= '1;
        end else begin
          rem_q   <= DEN_W'(sum_q[SUM_W-1:7]);
          ratio_q <= {sum_q[6:0], 16'h0000};
        end
      end
      ST_DIV: begin
        rem_q   <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        ratio_q <= {ratio_q[RATIO_W-2:0], trial_ge};
      end
      ST_SQR: begin
        if (mul_done) r2_q <= mul_prod[R2_W+15:16];
      end
      ST_CUBE: begin
        if (mul_done) r3_q <= mul_prod[R3_W+15:16];
      end
      ST_POLY1: begin
        // 11*r3 and 38*r2
        pos_q <= POS_W'({r3_q, 3'b000}) + POS_W'({r3_q, 1'b0}) + POS_W'(r3_q);
        neg_q <= NEG_W'({r2_q, 5'b00000}) + NEG_W'({r2_q, 2'b00}) + NEG_W'({r2_q, 1'b0});
      end
      ST_POLY2: begin
        // 5120*r
        pos_q <= pos_q + POS_W'({ratio_q, 12'h000}) + POS_W'({ratio_q, 10'h000});
      end
      ST_POLY3: begin
        // remaining 80*r and the offset
        pos_q <= pos_q + POS_W'({ratio_q, 6'h00}) + POS_W'({ratio_q, 4'h0}) + CURVE_OFFSET;
      end
      ST_SUB: begin
        // clamp at zero, then drop the factor of 512
        q5_q   <= (neg_ext >= pos_q) ? '0 : Q5_W'(t_diff[POS_W-1:9]);
        rem5_q <= '0;
      end
      ST_DIV5: begin
        q5_q   <= {q5_q[Q5_W-3:0], dig5};
        rem5_q <= rem5_full[2:0];
      end
      ST_FINISH: begin
        if (emit_go) begin
          conc_out_q <= conc;
          sum_out_q  <= sum_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.concentration   = conc_out_q;
  assign out_o.occupancy_total = sum_out_q;

  // a report only appears from the final state
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("report raised outside the final state");

  // an accepted transaction goes straight to the window check
  a_accept_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_RANGE)
    else $error("accepted transaction did not start the window check");

  // ratio division keeps its partial remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < den_q)
    else $error("ratio remainder reached the divisor");

  // divide-by-five remainder stays a valid residue
  a_div5_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV5 |-> rem5_q < 3'd5)
    else $error("divide-by-five remainder out of range");

  // a report clears the sum and restarts the window at its time
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> (sum_q == '0) && (start_q == $past(now_q)))
    else $error("window not restarted after a report");

endmodule

`default_nettype wire
